/* rtl/core/esc_pkg.sv */
// Shared types and constants for the environmental sensor compensation block.
package esc_pkg;

    // Raw reading: one transfer on the input side.
    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
        logic [15:0] raw_humidity;
    } sample_t;

    // Compensated result: one transfer on the output side.
    typedef struct packed {
        logic signed [31:0] temperature_out;
        logic [31:0]        pressure_out;
        logic [16:0]        humidity_out;
        logic               divisor_zero;
    } result_t;

    // Calibration register indexes.
    typedef enum logic [2:0] {
        CFG_TEMP_A  = 3'd0,
        CFG_TEMP_B  = 3'd1,
        CFG_PRESS_A = 3'd2,
        CFG_PRESS_B = 3'd3,
        CFG_PRESS_C = 3'd4,
        CFG_PRESS_D = 3'd5,
        CFG_MIXED   = 3'd6,
        CFG_HUM     = 3'd7
    } cfg_idx_t;

    localparam int CFG_W   = 40;
    localparam int DIV_W   = 64;

    localparam logic signed [32:0] T_FINE_P_OFS = 33'sd128000;
    localparam logic [31:0]        T_FINE_H_OFS = 32'd76800;
    localparam logic [20:0]        P_FULL_SCALE = 21'd1048576;
    localparam logic [11:0]        P_SCALE      = 12'd3125;
    localparam logic [63:0]        P_BIAS_47    = 64'h0000_8000_0000_0000;
    localparam logic [31:0]        H_MAX        = 32'd419430400;
    localparam logic [31:0]        H_OFS_F2     = 32'd2097152;
    localparam logic [31:0]        H_RND_F1     = 32'd16384;
    localparam logic [31:0]        H_OFS_MUL    = 32'd32768;
    localparam logic [31:0]        H_RND_F2     = 32'd8192;
    localparam logic [31:0]        T_RND        = 32'd128;

endpackage

/* rtl/core/esc_divider.sv */
// Pipelined unsigned 64-bit restoring divider, one quotient bit per stage.
module esc_divider (
    input  logic                        clk,
    input  logic [esc_pkg::DIV_W-1:0]   numer,
    input  logic [esc_pkg::DIV_W-1:0]   denom,
    output logic [esc_pkg::DIV_W-1:0]   quot
);

    localparam int W = esc_pkg::DIV_W;

    logic [W-1:0] rem_reg [W];
    logic [W-1:0] quo_reg [W];
    logic [W-1:0] den_reg [W];

    genvar k;
    generate
        for (k = 0; k < W; k++)
        begin : g_step
            logic [W-1:0] rem_in;
            logic [W-1:0] quo_in;
            logic [W-1:0] den_in;
            logic [W:0]   trial;
            logic [W:0]   diff;

            if (k == 0)
            begin : g_first
                assign rem_in = '0;
                assign quo_in = numer;
                assign den_in = denom;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            // Shift in the next numerator bit and try a subtract.
            assign trial = {rem_in, quo_in[W-1]};
            assign diff  = trial - {1'b0, den_in};

            always_ff @(posedge clk)
            begin
                if (!diff[W])
                begin
                    rem_reg[k] <= diff[W-1:0];
                    quo_reg[k] <= {quo_in[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= trial[W-1:0];
                    quo_reg[k] <= {quo_in[W-2:0], 1'b0};
                end
                den_reg[k] <= den_in;
            end
        end
    endgenerate

    assign quot = quo_reg[W-1];

endmodule

/* rtl/core/env_sensor_compensation.sv */
// Top level of the environmental sensor compensation pipeline.
// Throughput: one reading per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the 64-stage bit-serial pressure divider plus the multiply chain.
// Reset clears the valid bits and all calibration registers; payload is not reset.
// Results cannot be held off: done marks each result for exactly one cycle.
module env_sensor_compensation (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  esc_pkg::sample_t            sample,
    output logic                        done,
    output esc_pkg::result_t            result,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [esc_pkg::CFG_W-1:0]   cfg_data
);

    localparam int DEPTH     = 80;   // output register stage
    localparam int TEMP_LINE = 75;   // temperature from stage 4 to stage 79
    localparam int HUM_LINE  = 68;   // humidity from stage 11 to stage 79
    localparam int DIV_LINE  = esc_pkg::DIV_W;

    // ------------------------------------------------------------------
    // Calibration registers; user writes only while pipeline empty, not enforced.
    // ------------------------------------------------------------------
    logic [31:0] cal_temp_a_reg, cal_temp_b_reg, cal_press_a_reg, cal_press_b_reg;
    logic [31:0] cal_press_c_reg, cal_press_d_reg, cal_mixed_reg;
    logic [39:0] cal_hum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_a_reg  <= '0;
            cal_temp_b_reg  <= '0;
            cal_press_a_reg <= '0;
            cal_press_b_reg <= '0;
            cal_press_c_reg <= '0;
            cal_press_d_reg <= '0;
            cal_mixed_reg   <= '0;
            cal_hum_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (esc_pkg::cfg_idx_t'(cfg_index))
                esc_pkg::CFG_TEMP_A:  cal_temp_a_reg  <= cfg_data[31:0];
                esc_pkg::CFG_TEMP_B:  cal_temp_b_reg  <= cfg_data[31:0];
                esc_pkg::CFG_PRESS_A: cal_press_a_reg <= cfg_data[31:0];
                esc_pkg::CFG_PRESS_B: cal_press_b_reg <= cfg_data[31:0];
                esc_pkg::CFG_PRESS_C: cal_press_c_reg <= cfg_data[31:0];
                esc_pkg::CFG_PRESS_D: cal_press_d_reg <= cfg_data[31:0];
                esc_pkg::CFG_MIXED:   cal_mixed_reg   <= cfg_data[31:0];
                esc_pkg::CFG_HUM:     cal_hum_reg     <= cfg_data;
                default:              cal_hum_reg     <= cal_hum_reg;
            endcase
        end
    end

    // Unpack the coefficients.
    logic [15:0]        t1, p1;
    logic [7:0]         h1, h3;
    logic signed [15:0] t2, t3, h2, p2, p3, p4, p5, p6, p7, p8, p9, h4, h5;
    logic signed [7:0]  h6;

    assign t1 = cal_temp_a_reg[15:0];
    assign t2 = cal_temp_a_reg[31:16];
    assign t3 = cal_temp_b_reg[15:0];
    assign h2 = cal_temp_b_reg[31:16];
    assign p1 = cal_press_a_reg[15:0];
    assign p2 = cal_press_a_reg[31:16];
    assign p3 = cal_press_b_reg[15:0];
    assign p4 = cal_press_b_reg[31:16];
    assign p5 = cal_press_c_reg[15:0];
    assign p6 = cal_press_c_reg[31:16];
    assign p7 = cal_press_d_reg[15:0];
    assign p8 = cal_press_d_reg[31:16];
    assign p9 = cal_mixed_reg[15:0];
    assign h1 = cal_mixed_reg[23:16];
    assign h3 = cal_mixed_reg[31:24];
    assign h4 = cal_hum_reg[15:0];
    assign h5 = cal_hum_reg[31:16];
    assign h6 = cal_hum_reg[39:32];

    // Every transfer is taken; valid bits travel with the data.
    logic [DEPTH-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[DEPTH-2:0], start};
    end

    assign busy = 1'b0;
    assign done = vld_reg[DEPTH-1];

    // ------------------------------------------------------------------
    // Temperature, stages 1 to 4.
    // ------------------------------------------------------------------
    logic signed [17:0] t_d1;
    logic signed [16:0] t_d2;
    logic signed [33:0] t_p1, t_p2;
    logic signed [47:0] t_p3;
    logic [31:0]        t_x5;
    logic signed [32:0] pv1;

    logic [31:0] s1_a_reg, s1_bb_reg;
    logic [19:0] rp_reg [7];
    logic [15:0] rh_reg [5];
    logic [31:0] s2_ta_reg, s2_tb_reg, s3_tf_reg, s4_temp_reg, s4_hx_reg;
    logic signed [32:0] s4_v1_reg;

    assign t_d1 = $signed({1'b0, sample.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign t_d2 = $signed({1'b0, sample.raw_temperature[19:4]}) - $signed({1'b0, t1});
    assign t_p1 = t_d1 * t2;
    assign t_p2 = t_d2 * t_d2;
    assign t_p3 = ($signed(s1_bb_reg) >>> 12) * t3;
    assign t_x5 = {s3_tf_reg[29:0], 2'b00} + s3_tf_reg + esc_pkg::T_RND;
    assign pv1  = $signed({s3_tf_reg[31], s3_tf_reg}) - esc_pkg::T_FINE_P_OFS;

    always_ff @(posedge clk)
    begin
        s1_a_reg    <= t_p1[31:0];
        s1_bb_reg   <= t_p2[31:0];
        s2_ta_reg   <= 32'($signed(s1_a_reg) >>> 11);
        s2_tb_reg   <= t_p3[31:0];
        s3_tf_reg   <= s2_ta_reg + 32'($signed(s2_tb_reg) >>> 14);
        s4_temp_reg <= 32'($signed(t_x5) >>> 8);
        s4_v1_reg   <= pv1;
        s4_hx_reg   <= s3_tf_reg - esc_pkg::T_FINE_H_OFS;
    end

    // Hold the raw pressure and humidity until their branch needs them.
    always_ff @(posedge clk)
    begin
        rp_reg[0] <= sample.raw_pressure;
        rh_reg[0] <= sample.raw_humidity;
        for (int i = 1; i < 7; i++)
            rp_reg[i] <= rp_reg[i-1];
        for (int i = 1; i < 5; i++)
            rh_reg[i] <= rh_reg[i-1];
    end

    // ------------------------------------------------------------------
    // Pressure coefficients, stages 5 to 10.
    // ------------------------------------------------------------------
    logic signed [65:0] p_vv;
    logic signed [48:0] p_v1p5, p_v1p2;
    logic signed [79:0] p_vvp6, p_vvp3;
    logic [63:0]        p_p4sh, p_vsh;
    logic [79:0]        p_vp1;
    logic [20:0]        p_pr;
    logic [75:0]        p_num;
    logic [63:0]        p_nabs, p_dabs;

    logic [63:0] s5_vv_reg, s5_v1p5_reg, s5_v1p2_reg;
    logic [63:0] s6_vvp6_reg, s6_vvp3_reg, s6_v1p5_reg, s6_v1p2_reg;
    logic [63:0] s7_v2_reg, s7_va_reg;
    logic [63:0] s8_vp1_reg, s8_num0_reg;
    logic [63:0] s9_dv_reg, s9_num_reg;
    logic [63:0] s10_nmag_reg, s10_dmag_reg;
    logic        s10_neg_reg, s10_dz_reg;

    assign p_vv   = s4_v1_reg * s4_v1_reg;
    assign p_v1p5 = s4_v1_reg * p5;
    assign p_v1p2 = s4_v1_reg * p2;
    assign p_vvp6 = $signed(s5_vv_reg) * p6;
    assign p_vvp3 = $signed(s5_vv_reg) * p3;
    assign p_p4sh = {{48{p4[15]}}, p4} << 35;
    assign p_vsh  = s7_va_reg + esc_pkg::P_BIAS_47;
    assign p_vp1  = p_vsh * p1;
    assign p_pr   = esc_pkg::P_FULL_SCALE - {1'b0, rp_reg[6]};
    assign p_num  = s8_num0_reg * esc_pkg::P_SCALE;
    assign p_nabs = s9_num_reg[63] ? (64'd0 - s9_num_reg) : s9_num_reg;
    assign p_dabs = s9_dv_reg[63] ? (64'd0 - s9_dv_reg) : s9_dv_reg;

    always_ff @(posedge clk)
    begin
        s5_vv_reg    <= p_vv[63:0];
        s5_v1p5_reg  <= {{15{p_v1p5[48]}}, p_v1p5};
        s5_v1p2_reg  <= {{15{p_v1p2[48]}}, p_v1p2};
        s6_vvp6_reg  <= p_vvp6[63:0];
        s6_vvp3_reg  <= p_vvp3[63:0];
        s6_v1p5_reg  <= s5_v1p5_reg;
        s6_v1p2_reg  <= s5_v1p2_reg;
        s7_v2_reg    <= s6_vvp6_reg + (s6_v1p5_reg << 17) + p_p4sh;
        s7_va_reg    <= 64'($signed(s6_vvp3_reg) >>> 8) + (s6_v1p2_reg << 12);
        s8_vp1_reg   <= p_vp1[63:0];
        s8_num0_reg  <= ({43'd0, p_pr} << 31) - s7_v2_reg;
        s9_dv_reg    <= 64'($signed(s8_vp1_reg) >>> 33);
        s9_num_reg   <= p_num[63:0];
        // Split into magnitudes and a result sign for the unsigned divider.
        s10_nmag_reg <= p_nabs;
        s10_dmag_reg <= p_dabs;
        s10_neg_reg  <= s9_num_reg[63] ^ s9_dv_reg[63];
        s10_dz_reg   <= (s9_dv_reg == 64'd0);
    end

    // ------------------------------------------------------------------
    // Divider, stages 11 to 74; sign and zero flag ride alongside.
    // ------------------------------------------------------------------
    logic [63:0] div_q;
    logic        neg_line_reg [DIV_LINE];
    logic        dz_line_reg  [DIV_LINE];

    esc_divider u_div (
        .clk   (clk),
        .numer (s10_nmag_reg),
        .denom (s10_dmag_reg),
        .quot  (div_q)
    );

    always_ff @(posedge clk)
    begin
        neg_line_reg[0] <= s10_neg_reg;
        dz_line_reg[0]  <= s10_dz_reg;
        for (int i = 1; i < DIV_LINE; i++)
        begin
            neg_line_reg[i] <= neg_line_reg[i-1];
            dz_line_reg[i]  <= dz_line_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Pressure tail, stages 75 to 80.
    // ------------------------------------------------------------------
    logic signed [79:0] q_m1, q_v2b;
    logic [63:0]        q_pp0_w;
    logic [31:0]        q_pp1_w, q_pp2_w;
    logic [63:0]        q_sum_sh;

    logic [63:0] s75_p_reg;
    logic [63:0] s76_p_reg, s76_pq_reg, s76_m1_reg, s76_v2b_reg;
    logic [63:0] s77_p_reg, s77_v2b_reg, s77_pp0_reg;
    logic [31:0] s77_pp1_reg, s77_pp2_reg;
    logic [63:0] s78_p_reg, s78_v2b_reg, s78_m2_reg;
    logic [63:0] s79_sum_reg;
    logic [4:0]  dz_tail_reg;

    assign q_m1    = p9 * $signed(64'($signed(s75_p_reg) >>> 13));
    assign q_v2b   = p8 * $signed(s75_p_reg);
    // Low 64 bits of the product from three 32x32 partial products.
    assign q_pp0_w = s76_m1_reg[31:0] * s76_pq_reg[31:0];
    assign q_pp1_w = s76_m1_reg[63:32] * s76_pq_reg[31:0];
    assign q_pp2_w = s76_m1_reg[31:0] * s76_pq_reg[63:32];
    assign q_sum_sh = 64'($signed(s79_sum_reg) >>> 8);

    always_ff @(posedge clk)
    begin
        s75_p_reg   <= neg_line_reg[DIV_LINE-1] ? (64'd0 - div_q) : div_q;
        s76_p_reg   <= s75_p_reg;
        s76_pq_reg  <= 64'($signed(s75_p_reg) >>> 13);
        s76_m1_reg  <= q_m1[63:0];
        s76_v2b_reg <= q_v2b[63:0];
        s77_p_reg   <= s76_p_reg;
        s77_v2b_reg <= s76_v2b_reg;
        s77_pp0_reg <= q_pp0_w;
        s77_pp1_reg <= q_pp1_w;
        s77_pp2_reg <= q_pp2_w;
        s78_p_reg   <= s77_p_reg;
        s78_v2b_reg <= s77_v2b_reg;
        s78_m2_reg  <= s77_pp0_reg + {s77_pp1_reg + s77_pp2_reg, 32'd0};
        s79_sum_reg <= s78_p_reg + 64'($signed(s78_m2_reg) >>> 25)
                     + 64'($signed(s78_v2b_reg) >>> 19);
        dz_tail_reg <= {dz_tail_reg[3:0], dz_line_reg[DIV_LINE-1]};
    end

    // ------------------------------------------------------------------
    // Humidity, stages 5 to 11.
    // ------------------------------------------------------------------
    logic signed [47:0] h_x5;
    logic signed [39:0] h_x6;
    logic signed [40:0] h_x3;
    logic [31:0]        h_f1, h_ma, h_mb, h_f2a, h_f2, h_s, h_x, h_x_sat;
    logic [31:0]        h_h2, h_h4;

    logic [31:0] h5_x5_reg, h5_x6_reg, h5_x3_reg;
    logic [31:0] h6_f1_reg, h6_pr_reg;
    logic [31:0] h7_f1_reg, h7_f2h_reg;
    logic [31:0] h8_xx_reg, h9_xx_reg, h9_ss_reg, h10_xx_reg, h10_sh_reg;
    logic [16:0] h11_hum_reg;

    assign h_x5  = $signed(s4_hx_reg) * h5;
    assign h_x6  = $signed(s4_hx_reg) * h6;
    assign h_x3  = $signed(s4_hx_reg) * $signed({1'b0, h3});
    assign h_h4  = {{16{h4[15]}}, h4};
    assign h_h2  = {{16{h2[15]}}, h2};
    assign h_f1  = 32'($signed({2'b00, rh_reg[4], 14'd0} - (h_h4 << 20) - h5_x5_reg
                               + esc_pkg::H_RND_F1) >>> 15);
    assign h_ma  = 32'($signed(h5_x6_reg) >>> 10);
    assign h_mb  = 32'($signed(h5_x3_reg) >>> 11) + esc_pkg::H_OFS_MUL;
    assign h_f2a = 32'($signed(h6_pr_reg) >>> 10) + esc_pkg::H_OFS_F2;
    assign h_f2  = 32'($signed(h7_f2h_reg + esc_pkg::H_RND_F2) >>> 14);
    assign h_s   = 32'($signed(h8_xx_reg) >>> 15);
    assign h_x   = h10_xx_reg - 32'($signed(h10_sh_reg) >>> 4);

    // Clamp to the valid range before dropping the fraction bits.
    always_comb
    begin
        if (h_x[31])
            h_x_sat = 32'd0;
        else if (h_x > esc_pkg::H_MAX)
            h_x_sat = esc_pkg::H_MAX;
        else
            h_x_sat = h_x;
    end

    always_ff @(posedge clk)
    begin
        h5_x5_reg   <= h_x5[31:0];
        h5_x6_reg   <= h_x6[31:0];
        h5_x3_reg   <= h_x3[31:0];
        h6_f1_reg   <= h_f1;
        h6_pr_reg   <= h_ma * h_mb;
        h7_f1_reg   <= h6_f1_reg;
        h7_f2h_reg  <= h_f2a * h_h2;
        h8_xx_reg   <= h7_f1_reg * h_f2;
        h9_xx_reg   <= h8_xx_reg;
        h9_ss_reg   <= h_s * h_s;
        h10_xx_reg  <= h9_xx_reg;
        h10_sh_reg  <= 32'($signed(h9_ss_reg) >>> 7) * {24'd0, h1};
        h11_hum_reg <= h_x_sat[28:12];
    end

    // ------------------------------------------------------------------
    // Align temperature and humidity with the pressure result.
    // ------------------------------------------------------------------
    logic [31:0] temp_line_reg [TEMP_LINE];
    logic [16:0] hum_line_reg  [HUM_LINE];

    always_ff @(posedge clk)
    begin
        temp_line_reg[0] <= s4_temp_reg;
        for (int i = 1; i < TEMP_LINE; i++)
            temp_line_reg[i] <= temp_line_reg[i-1];
        hum_line_reg[0] <= h11_hum_reg;
        for (int i = 1; i < HUM_LINE; i++)
            hum_line_reg[i] <= hum_line_reg[i-1];
    end

    // Output register, stage 80; drop pressure to zero on a zero divisor.
    esc_pkg::result_t result_reg;

    always_ff @(posedge clk)
    begin
        result_reg.temperature_out <= temp_line_reg[TEMP_LINE-1];
        result_reg.humidity_out    <= hum_line_reg[HUM_LINE-1];
        result_reg.divisor_zero    <= dz_tail_reg[4];
        if (dz_tail_reg[4])
            result_reg.pressure_out <= 32'd0;
        else
            result_reg.pressure_out <= q_sum_sh[31:0] + ({{16{p7[15]}}, p7} << 4);
    end

    assign result = result_reg;

endmodule
